// ----- hdl/dpdr_pkg.sv -----
// Package for the dual-loop differential drive controller: widths, constants,
// item and configuration types, and the controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps

package dpdr_pkg;

   localparam int RAMP_STEPS  = 10;
   localparam int RAMP_W      = $clog2(RAMP_STEPS + 1);

   localparam int POS_W       = 24;
   localparam int GAIN_W      = 16;
   localparam int DRIVE_W     = 16;
   localparam int TIME_W      = 16;
   localparam int ERR_W       = POS_W + 1;
   localparam int DIFF_W      = POS_W + 2;
   localparam int INTEG_W     = 40;
   localparam int MUL_A_W     = INTEG_W;
   localparam int PROD_W      = MUL_A_W + GAIN_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int Q_FRAC      = 8;
   localparam int Q_BIAS      = 2 ** Q_FRAC - 1;
   localparam int PWR_W       = ACC_W - Q_FRAC;
   localparam int CLAMP_W     = 21;
   localparam int SUM_W       = 27;
   localparam int MAG_W       = 26;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_MUL   = (2 ** RECIP_SHIFT) / RAMP_STEPS;
   localparam int RPROD_W     = RECIP_SHIFT + MAG_W;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic signed [GAIN_W-1:0] MIN_DRIVE_RESET = GAIN_W'(10);

   typedef struct packed {
      logic                    restart;
      logic signed [POS_W-1:0] left_position;
      logic signed [POS_W-1:0] right_position;
   } req_item_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
      logic                      done_res;
   } rsp_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  target_ticks;
      logic signed [GAIN_W-1:0] kp_distance;
      logic signed [GAIN_W-1:0] kd_distance;
      logic signed [GAIN_W-1:0] kp_balance;
      logic signed [GAIN_W-1:0] ki_balance;
      logic signed [GAIN_W-1:0] kd_balance;
      logic signed [GAIN_W-1:0] min_drive;
      logic [TIME_W-1:0]        timeout_periods;
   } cfg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_TICKS    = 3'd0,
      CSR_KP_DISTANCE     = 3'd1,
      CSR_KD_DISTANCE     = 3'd2,
      CSR_KP_BALANCE      = 3'd3,
      CSR_KI_BALANCE      = 3'd4,
      CSR_KD_BALANCE      = 3'd5,
      CSR_MIN_DRIVE       = 3'd6,
      CSR_TIMEOUT_PERIODS = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_ED,
      MUL_DD,
      MUL_EB,
      MUL_INT,
      MUL_DB
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        scale;
      logic        ramp;
      logic        recip;
      logic        fix;
      logic        publish;
      logic        publish_done;
   } dp_cmd_type;

   typedef struct packed {
      logic expired;
   } dp_status_type;

endpackage

// ----- hdl/dpdr_csr.sv -----
// Configuration register file for the drive controller.
// Depends on dpdr_pkg.
`timescale 1ns / 1ps

module dpdr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [dpdr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpdr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dpdr_pkg::cfg_type                cfg
);

   dpdr_pkg::cfg_type cfg_ff;

   function automatic dpdr_pkg::cfg_type reset_cfg();
      dpdr_pkg::cfg_type c;
      c           = '0;
      c.min_drive = dpdr_pkg::MIN_DRIVE_RESET;
      return c;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= reset_cfg();
      end else if (csr_write_en) begin
         unique case (dpdr_pkg::csr_index_type'(csr_index))
            dpdr_pkg::CSR_TARGET_TICKS: begin
               cfg_ff.target_ticks <= csr_wdata[dpdr_pkg::POS_W-1:0];
            end
            dpdr_pkg::CSR_KP_DISTANCE: begin
               cfg_ff.kp_distance <= csr_wdata[dpdr_pkg::GAIN_W-1:0];
            end
            dpdr_pkg::CSR_KD_DISTANCE: begin
               cfg_ff.kd_distance <= csr_wdata[dpdr_pkg::GAIN_W-1:0];
            end
            dpdr_pkg::CSR_KP_BALANCE: begin
               cfg_ff.kp_balance <= csr_wdata[dpdr_pkg::GAIN_W-1:0];
            end
            dpdr_pkg::CSR_KI_BALANCE: begin
               cfg_ff.ki_balance <= csr_wdata[dpdr_pkg::GAIN_W-1:0];
            end
            dpdr_pkg::CSR_KD_BALANCE: begin
               cfg_ff.kd_balance <= csr_wdata[dpdr_pkg::GAIN_W-1:0];
            end
            dpdr_pkg::CSR_MIN_DRIVE: begin
               cfg_ff.min_drive <= csr_wdata[dpdr_pkg::GAIN_W-1:0];
            end
            dpdr_pkg::CSR_TIMEOUT_PERIODS: begin
               cfg_ff.timeout_periods <= csr_wdata[dpdr_pkg::TIME_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/dpdr_ctrl.sv -----
// Sequencing state machine for the drive controller: accepts an item, runs the
// error phase, then product, scaling and division unless timed out, hands off.
// Depends on dpdr_pkg.
`timescale 1ns / 1ps

module dpdr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  dpdr_pkg::dp_status_type  status,
   output dpdr_pkg::dp_cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_MUL,
      S_DRAIN,
      S_SCALE,
      S_RAMP,
      S_RECIP,
      S_FIX,
      S_PUT
   } state_type;

   state_type             state_ff;
   dpdr_pkg::mul_sel_type mul_sel_ff;
   logic                  rsp_valid_ff;
   logic                  expired_ff;
   logic                  slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd              = '0;
      cmd.mul_sel      = mul_sel_ff;
      cmd.publish_done = expired_ff;
      unique case (state_ff)
         S_IDLE:  cmd.load    = req_valid;
         S_ERR:   cmd.step    = !status.expired;
         S_MUL:   cmd.mul_en  = 1'b1;
         S_DRAIN: cmd.mul_en  = 1'b0;
         S_SCALE: cmd.scale   = 1'b1;
         S_RAMP:  cmd.ramp    = 1'b1;
         S_RECIP: cmd.recip   = 1'b1;
         S_FIX:   cmd.fix     = 1'b1;
         S_PUT:   cmd.publish = slot_free;
         default: cmd.load    = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_sel_ff   <= dpdr_pkg::MUL_ED;
         rsp_valid_ff <= 1'b0;
         expired_ff   <= 1'b0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_ERR;
               end
            end
            S_ERR: begin
               expired_ff <= status.expired;
               mul_sel_ff <= dpdr_pkg::MUL_ED;
               state_ff   <= status.expired ? S_PUT : S_MUL;
            end
            S_MUL: begin
               unique case (mul_sel_ff)
                  dpdr_pkg::MUL_ED:  mul_sel_ff <= dpdr_pkg::MUL_DD;
                  dpdr_pkg::MUL_DD:  mul_sel_ff <= dpdr_pkg::MUL_EB;
                  dpdr_pkg::MUL_EB:  mul_sel_ff <= dpdr_pkg::MUL_INT;
                  dpdr_pkg::MUL_INT: mul_sel_ff <= dpdr_pkg::MUL_DB;
                  default:           mul_sel_ff <= dpdr_pkg::MUL_ED;
               endcase
               if (mul_sel_ff == dpdr_pkg::MUL_DB) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_RAMP;
            S_RAMP:  state_ff <= S_RECIP;
            S_RECIP: state_ff <= S_FIX;
            S_FIX:   state_ff <= S_PUT;
            S_PUT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_err: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_ERR))
      else $error("accepted item did not enter error phase");

   a_expired_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERR && status.expired) |=> (state_ff == S_PUT && expired_ff))
      else $error("expired tick did not go straight to hand-off");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.publish)
      else $error("result published over a waiting item");

endmodule

// ----- hdl/dpdr_dp.sv -----
// Datapath for the drive controller: loop state, shared gain multiplier,
// accumulators, ramp scaling and reciprocal division by the ramp length.
// Depends on dpdr_pkg.
`timescale 1ns / 1ps

module dpdr_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  dpdr_pkg::cfg_type        cfg,
   input  dpdr_pkg::req_item_type   req_item,
   input  dpdr_pkg::dp_cmd_type     cmd,
   output dpdr_pkg::dp_status_type  status,
   output dpdr_pkg::rsp_item_type   rsp_item
);

   localparam int ERR_W   = dpdr_pkg::ERR_W;
   localparam int DIFF_W  = dpdr_pkg::DIFF_W;
   localparam int INTEG_W = dpdr_pkg::INTEG_W;
   localparam int ACC_W   = dpdr_pkg::ACC_W;
   localparam int PWR_W   = dpdr_pkg::PWR_W;
   localparam int SUM_W   = dpdr_pkg::SUM_W;
   localparam int MAG_W   = dpdr_pkg::MAG_W;
   localparam int RAMP_W  = dpdr_pkg::RAMP_W;
   localparam int TIME_W  = dpdr_pkg::TIME_W;
   localparam int DRIVE_W = dpdr_pkg::DRIVE_W;
   localparam int CLAMP_W = dpdr_pkg::CLAMP_W;
   localparam int RPROD_W = dpdr_pkg::RPROD_W;

   localparam logic [RAMP_W-1:0] RAMP_MAX = RAMP_W'(dpdr_pkg::RAMP_STEPS);
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   function automatic logic signed [PWR_W-1:0] div_q(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + (v[ACC_W-1] ? ACC_W'(dpdr_pkg::Q_BIAS) : '0);
      return t[ACC_W-1:dpdr_pkg::Q_FRAC];
   endfunction

   function automatic logic signed [CLAMP_W-1:0] clamp_pwr(input logic signed [PWR_W:0] v);
      logic fits;
      fits = (&v[PWR_W:CLAMP_W-1]) || !(|v[PWR_W:CLAMP_W-1]);
      if (fits) begin
         return v[CLAMP_W-1:0];
      end
      return v[PWR_W] ? {1'b1, {(CLAMP_W-1){1'b0}}} : {1'b0, {(CLAMP_W-1){1'b1}}};
   endfunction

   function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (&v[SUM_W-1:DRIVE_W-1]) || !(|v[SUM_W-1:DRIVE_W-1]);
      if (fits) begin
         return v[DRIVE_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
   endfunction

   // loop state
   logic signed [dpdr_pkg::POS_W-1:0] pos_l_ff, pos_r_ff;
   logic signed [ERR_W-1:0]           last_d_ff, last_b_ff;
   logic signed [INTEG_W-1:0]         integ_ff;
   logic [RAMP_W-1:0]                 ramp_ff;
   logic [TIME_W-1:0]                 elapsed_ff;

   // working registers
   logic signed [ERR_W-1:0]           ed_ff, eb_ff;
   logic signed [DIFF_W-1:0]          dd_ff, db_ff;
   logic [RAMP_W-1:0]                 rr_ff;
   logic signed [dpdr_pkg::PROD_W-1:0] prod_ff;
   logic                              prod_vld_ff;
   logic                              prod_to_b_ff;
   logic signed [ACC_W-1:0]           acc_d_ff, acc_b_ff;
   logic signed [PWR_W-1:0]           pd_ff, pb_ff;
   logic signed [SUM_W-1:0]           sum_l_ff, sum_r_ff;
   logic                              neg_l_ff, neg_r_ff;
   logic [MAG_W-1:0]                  mag_l_ff, mag_r_ff;
   logic [MAG_W-1:0]                  qh_l_ff, qh_r_ff;
   logic signed [SUM_W-1:0]           q_l_ff, q_r_ff;
   dpdr_pkg::rsp_item_type            rsp_item_ff;

   // error phase
   logic signed [ERR_W-1:0]           lr_sum;
   logic signed [DIFF_W-1:0]          diff, diff_half;
   logic signed [ERR_W-1:0]           ed, eb;
   logic signed [DIFF_W-1:0]          dd, db;
   logic signed [INTEG_W:0]           integ_sum;
   logic signed [INTEG_W-1:0]         integ_sat, integ_new;
   logic [RAMP_W-1:0]                 rr_now;

   // products and scaling
   logic signed [dpdr_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dpdr_pkg::GAIN_W-1:0]  mul_b;
   logic                                mul_to_b;
   logic signed [SUM_W-1:0]             base;
   logic signed [CLAMP_W-1:0]           x_l, x_r;
   logic signed [SUM_W-1:0]             sum_l, sum_r;
   logic [SUM_W-1:0]                    abs_l, abs_r;
   logic [MAG_W-1:0]                    mag_l, mag_r;
   logic [RPROD_W-1:0]                  rprod_l, rprod_r;
   logic [MAG_W-1:0]                    rem_l, rem_r;
   logic [MAG_W-1:0]                    qf_l, qf_r;

   assign lr_sum    = ERR_W'(pos_l_ff) + ERR_W'(pos_r_ff);
   assign diff      = {cfg.target_ticks[dpdr_pkg::POS_W-1], cfg.target_ticks, 1'b0}
                      - DIFF_W'(lr_sum);
   assign diff_half = (diff + DIFF_W'(diff[DIFF_W-1])) >>> 1;
   assign ed        = diff_half[ERR_W-1:0];
   assign eb        = ERR_W'(pos_l_ff) - ERR_W'(pos_r_ff);
   assign dd        = DIFF_W'(ed) - DIFF_W'(last_d_ff);
   assign db        = DIFF_W'(eb) - DIFF_W'(last_b_ff);
   assign integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(eb);

   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
      integ_new = (eb == '0) ? '0 : integ_sat;
      rr_now    = (ramp_ff < RAMP_MAX) ? ramp_ff : RAMP_MAX;
   end

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mul_to_b = 1'b0;
      case (cmd.mul_sel)
         dpdr_pkg::MUL_ED: begin
            mul_a = dpdr_pkg::MUL_A_W'(ed_ff);
            mul_b = cfg.kp_distance;
         end
         dpdr_pkg::MUL_DD: begin
            mul_a = dpdr_pkg::MUL_A_W'(dd_ff);
            mul_b = cfg.kd_distance;
         end
         dpdr_pkg::MUL_EB: begin
            mul_a = dpdr_pkg::MUL_A_W'(eb_ff);
            mul_b = cfg.kp_balance;
         end
         dpdr_pkg::MUL_INT: begin
            mul_a = integ_ff;
            mul_b = cfg.ki_balance;
         end
         dpdr_pkg::MUL_DB: begin
            mul_a = dpdr_pkg::MUL_A_W'(db_ff);
            mul_b = cfg.kd_balance;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      case (cmd.mul_sel) inside
         dpdr_pkg::MUL_EB, dpdr_pkg::MUL_INT, dpdr_pkg::MUL_DB: mul_to_b = 1'b1;
         default:                                                 mul_to_b = 1'b0;
      endcase
   end

   // ramp scaling: min_drive * steps + clamp(pd -/+ pb) * r
   assign base  = SUM_W'(cfg.min_drive) * SUM_W'(dpdr_pkg::RAMP_STEPS);
   assign x_l   = clamp_pwr((PWR_W+1)'(pd_ff) - (PWR_W+1)'(pb_ff));
   assign x_r   = clamp_pwr((PWR_W+1)'(pd_ff) + (PWR_W+1)'(pb_ff));
   assign sum_l = base + SUM_W'(x_l) * SUM_W'(rr_ff);
   assign sum_r = base + SUM_W'(x_r) * SUM_W'(rr_ff);

   // division by the ramp length: reciprocal estimate, then one correction
   assign abs_l   = sum_l_ff[SUM_W-1] ? -sum_l_ff : sum_l_ff;
   assign abs_r   = sum_r_ff[SUM_W-1] ? -sum_r_ff : sum_r_ff;
   assign mag_l   = abs_l[MAG_W-1:0];
   assign mag_r   = abs_r[MAG_W-1:0];
   assign rprod_l = RPROD_W'(mag_l) * RPROD_W'(dpdr_pkg::RECIP_MUL);
   assign rprod_r = RPROD_W'(mag_r) * RPROD_W'(dpdr_pkg::RECIP_MUL);
   assign rem_l   = mag_l_ff - qh_l_ff * MAG_W'(dpdr_pkg::RAMP_STEPS);
   assign rem_r   = mag_r_ff - qh_r_ff * MAG_W'(dpdr_pkg::RAMP_STEPS);
   assign qf_l    = (rem_l >= MAG_W'(dpdr_pkg::RAMP_STEPS)) ? qh_l_ff + 1'b1 : qh_l_ff;
   assign qf_r    = (rem_r >= MAG_W'(dpdr_pkg::RAMP_STEPS)) ? qh_r_ff + 1'b1 : qh_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_d_ff   <= '0;
         last_b_ff   <= '0;
         integ_ff    <= '0;
         ramp_ff     <= RAMP_W'(1);
         elapsed_ff  <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
         if (cmd.load && req_item.restart) begin
            last_d_ff  <= '0;
            last_b_ff  <= '0;
            integ_ff   <= '0;
            ramp_ff    <= RAMP_W'(1);
            elapsed_ff <= '0;
         end
         if (cmd.step) begin
            last_d_ff  <= ed;
            last_b_ff  <= eb;
            integ_ff   <= integ_new;
            ramp_ff    <= (ramp_ff < RAMP_MAX) ? ramp_ff + 1'b1 : RAMP_MAX;
            elapsed_ff <= elapsed_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_l_ff <= req_item.left_position;
         pos_r_ff <= req_item.right_position;
      end
      if (cmd.step) begin
         ed_ff    <= ed;
         eb_ff    <= eb;
         dd_ff    <= dd;
         db_ff    <= db;
         rr_ff    <= rr_now;
         acc_d_ff <= '0;
         acc_b_ff <= '0;
      end else if (prod_vld_ff) begin
         if (prod_to_b_ff) begin
            acc_b_ff <= acc_b_ff + ACC_W'(prod_ff);
         end else begin
            acc_d_ff <= acc_d_ff + ACC_W'(prod_ff);
         end
      end
      if (cmd.mul_en) begin
         prod_ff      <= mul_a * mul_b;
         prod_to_b_ff <= mul_to_b;
      end
      if (cmd.scale) begin
         pd_ff <= div_q(acc_d_ff);
         pb_ff <= div_q(acc_b_ff);
      end
      if (cmd.ramp) begin
         sum_l_ff <= sum_l;
         sum_r_ff <= sum_r;
      end
      if (cmd.recip) begin
         neg_l_ff <= sum_l_ff[SUM_W-1];
         neg_r_ff <= sum_r_ff[SUM_W-1];
         mag_l_ff <= mag_l;
         mag_r_ff <= mag_r;
         qh_l_ff  <= rprod_l[dpdr_pkg::RECIP_SHIFT +: MAG_W];
         qh_r_ff  <= rprod_r[dpdr_pkg::RECIP_SHIFT +: MAG_W];
      end
      if (cmd.fix) begin
         q_l_ff <= neg_l_ff ? -SUM_W'(qf_l) : SUM_W'(qf_l);
         q_r_ff <= neg_r_ff ? -SUM_W'(qf_r) : SUM_W'(qf_r);
      end
      if (cmd.publish) begin
         if (cmd.publish_done) begin
            rsp_item_ff.left_drive  <= '0;
            rsp_item_ff.right_drive <= '0;
            rsp_item_ff.done_res    <= 1'b1;
         end else begin
            rsp_item_ff.left_drive  <= sat_drive(q_l_ff);
            rsp_item_ff.right_drive <= sat_drive(q_r_ff);
            rsp_item_ff.done_res    <= 1'b0;
         end
      end
   end

   assign status.expired = (elapsed_ff >= cfg.timeout_periods);
   assign rsp_item       = rsp_item_ff;

   a_ramp_range: assert property (@(posedge clock) disable iff (reset)
      (ramp_ff != '0) && (ramp_ff <= RAMP_MAX))
      else $error("ramp count out of range");

   a_elapsed_step: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (elapsed_ff == $past(elapsed_ff) + 1'b1))
      else $error("elapsed count did not advance on a running tick");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.publish) && rsp_item_ff.done_res |->
         (rsp_item_ff.left_drive == '0) && (rsp_item_ff.right_drive == '0))
      else $error("drives not zero on a finished move");

endmodule

// ----- hdl/dual_pid_drive_ramp_top.sv -----
// Running tick: the serial phases are error, five shared-multiplier products, drain,
// scale, ramp, reciprocal, correction and hand-off; a timed-out tick goes from
// error straight to hand-off.
// One item in flight; a new item is taken once the previous result is registered.
// Synchronous active-high reset clears loop state, control state and handshakes.
`timescale 1ns / 1ps

module dual_pid_drive_ramp_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dpdr_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dpdr_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_write_en,
   input  logic [dpdr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dpdr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dpdr_pkg::cfg_type       cfg;
   dpdr_pkg::dp_cmd_type    cmd;
   dpdr_pkg::dp_status_type status;

   dpdr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   dpdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpdr_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
